[src/ftb_pkg.sv]
// ----------------------------------------------------------------------------
// ftb_pkg
// Shared codes and helpers for the framed packet transmit buffer.
// ----------------------------------------------------------------------------
package ftb_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_READY = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REJECTED  = 2'd1,
        ST_IGNORED   = 2'd2,
        ST_DISCARDED = 2'd3
    } status_t;

    // sync, sync, id, length, checksum
    localparam int unsigned FRAME_OVERHEAD = 5;
    localparam int unsigned HEADER_BYTES   = 4;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // register indexes on the configuration port
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    function automatic logic [7:0] twos_neg(input logic [7:0] s);
        return (s ^ BYTE_MASK) + 8'd1;
    endfunction

endpackage

[src/ftb_ram.sv]
// ----------------------------------------------------------------------------
// ftb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ftb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/framed_packet_tx_buffer.sv]
// ----------------------------------------------------------------------------
// framed_packet_tx_buffer
// Transmit framer: stores sync bytes, id, length, payload and checksum of each
// packet in a linear byte buffer and hands the bytes out one at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: op with
//   packet_id, payload_length or data_byte. Output channel (out_valid /
//   out_stall) returns exactly one result word per input word, in order.
//   Sync bytes are set over the APB port (0x0 first, 0x4 second) while idle.
// Timing:
//   out_valid rises at the clock edge after the one that takes its word, unless
//   a stalled result holds the output register. Payload bytes and ready words
//   go back to back unless the output stalls; a closing byte or start word
//   stalls the input while the sequencer writes the rest: one write port.
// Stall:
//   One finished result may wait in the output register while the next word
//   is taken into the pending stage; after that in_stall rises until
//   out_stall drops.
// Reset:
//   Positions, flags, sum and sync bytes clear; buffer contents are left as is
//   and are only ever read below the write position.
// ----------------------------------------------------------------------------
module framed_packet_tx_buffer #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            op,
    input  logic [7:0]            packet_id,
    input  logic [7:0]            payload_length,
    input  logic [7:0]            data_byte,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  tx_valid,
    output logic [7:0]            tx_byte,
    output logic                  packet_complete,
    output ftb_pkg::status_t      status,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    import ftb_pkg::*;

    localparam int PW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int SW = ((PW > 9) ? PW : 9) + 1;

    // configuration
    logic [7:0] sync_first_reg, sync_second_reg;
    logic       cfg_wr;

    // framing state
    logic [PW-1:0] wr_pos_reg, wr_pos_next;
    logic [PW-1:0] rd_pos_reg, rd_pos_next;
    logic          open_reg, open_next;
    logic          discard_reg, discard_next;
    logic [7:0]    remain_reg, remain_next;
    logic [7:0]    sum_reg, sum_next;

    // write sequencer for header and checksum bytes
    logic [2:0]    seq_cnt_reg, seq_cnt_next;
    logic [AW-1:0] seq_addr_reg, seq_addr_next;
    logic [7:0]    seq_q_reg [HEADER_BYTES];
    logic [7:0]    seq_q_next [HEADER_BYTES];

    // RAM ports
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data, rd_data;

    // pending stage and output register
    logic          p_valid_reg, p_valid_next;
    logic          p_read_reg;
    logic          p_done_reg;
    status_t       p_status_reg;
    logic          res_read, res_done;
    status_t       res_status;

    logic          out_valid_reg, out_valid_next;
    logic          o_tx_valid_reg;
    logic [7:0]    o_tx_byte_reg;
    logic          o_done_reg;
    status_t       o_status_reg;

    logic          in_fire, p_move;
    logic [SW-1:0] frame_end;
    logic [7:0]    sum_data;
    logic [PW-1:0] rd_pos_inc;

    assign p_move   = p_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = (seq_cnt_reg != 3'd0) || (p_valid_reg && !p_move);
    assign in_fire  = in_valid && !in_stall;

    assign frame_end  = SW'(payload_length) + SW'(FRAME_OVERHEAD) + SW'(wr_pos_reg);
    assign sum_data   = sum_reg + data_byte;
    assign rd_pos_inc = rd_pos_reg + PW'(1);

    // ------------------------------------------------------------------
    // APB configuration
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SYNC_SECOND) ? {24'd0, sync_second_reg}
                                                  : {24'd0, sync_first_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= 8'd0;
            sync_second_reg <= 8'd0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SYNC_FIRST)
            begin
                sync_first_reg <= pwdata[7:0];
            end
            else
            begin
                sync_second_reg <= pwdata[7:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Item decode and state update
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_pos_next   = wr_pos_reg;
        rd_pos_next   = rd_pos_reg;
        open_next     = open_reg;
        discard_next  = discard_reg;
        remain_next   = remain_reg;
        sum_next      = sum_reg;
        seq_cnt_next  = seq_cnt_reg;
        seq_addr_next = seq_addr_reg;
        seq_q_next    = seq_q_reg;
        wr_en         = 1'b0;
        wr_addr       = wr_pos_reg[AW-1:0];
        wr_data       = data_byte;
        rd_en         = 1'b0;
        res_read      = 1'b0;
        res_done      = 1'b0;
        res_status    = ST_IGNORED;

        if (seq_cnt_reg != 3'd0)
        begin
            wr_en         = 1'b1;
            wr_addr       = seq_addr_reg;
            wr_data       = seq_q_reg[0];
            seq_addr_next = seq_addr_reg + AW'(1);
            seq_cnt_next  = seq_cnt_reg - 3'd1;
            for (int i = 0; i < HEADER_BYTES - 1; i++)
            begin
                seq_q_next[i] = seq_q_reg[i+1];
            end
        end

        if (in_fire)
        begin
            unique case (op)
                OP_START:
                begin
                    if (!open_reg && !discard_reg)
                    begin
                        if (frame_end > SW'(BUFFER_DEPTH))
                        begin
                            res_status = ST_REJECTED;
                            if (payload_length != 8'd0)
                            begin
                                discard_next = 1'b1;
                                remain_next  = payload_length;
                            end
                        end
                        else
                        begin
                            res_status    = ST_OK;
                            // first sync byte now, the rest from the sequencer
                            wr_en         = 1'b1;
                            wr_data       = sync_first_reg;
                            seq_q_next[0] = sync_second_reg;
                            seq_q_next[1] = packet_id;
                            seq_q_next[2] = payload_length;
                            seq_q_next[3] = twos_neg(packet_id + payload_length);
                            seq_addr_next = wr_pos_reg[AW-1:0] + AW'(1);
                            sum_next      = packet_id + payload_length;
                            remain_next   = payload_length;
                            if (payload_length == 8'd0)
                            begin
                                res_done     = 1'b1;
                                open_next    = 1'b0;
                                seq_cnt_next = 3'd4;
                                wr_pos_next  = wr_pos_reg + PW'(FRAME_OVERHEAD);
                            end
                            else
                            begin
                                open_next    = 1'b1;
                                seq_cnt_next = 3'd3;
                                wr_pos_next  = wr_pos_reg + PW'(HEADER_BYTES);
                            end
                        end
                    end
                end
                OP_DATA:
                begin
                    if (open_reg)
                    begin
                        res_status = ST_OK;
                        wr_en      = 1'b1;
                        sum_next   = sum_data;
                        // an open packet always expects at least one byte
                        if (remain_reg == 8'd1)
                        begin
                            res_done      = 1'b1;
                            open_next     = 1'b0;
                            remain_next   = 8'd0;
                            seq_q_next[0] = twos_neg(sum_data);
                            seq_addr_next = wr_pos_reg[AW-1:0] + AW'(1);
                            seq_cnt_next  = 3'd1;
                            wr_pos_next   = wr_pos_reg + PW'(2);
                        end
                        else
                        begin
                            remain_next = remain_reg - 8'd1;
                            wr_pos_next = wr_pos_reg + PW'(1);
                        end
                    end
                    else if (discard_reg)
                    begin
                        res_status  = ST_DISCARDED;
                        remain_next = remain_reg - 8'd1;
                        if (remain_reg == 8'd1)
                        begin
                            discard_next = 1'b0;
                        end
                    end
                end
                OP_READY:
                begin
                    if (!open_reg)
                    begin
                        if (rd_pos_reg < wr_pos_reg)
                        begin
                            res_status = ST_OK;
                            res_read   = 1'b1;
                            rd_en      = 1'b1;
                            if (rd_pos_inc >= wr_pos_reg)
                            begin
                                rd_pos_next = '0;
                                wr_pos_next = '0;
                            end
                            else
                            begin
                                rd_pos_next = rd_pos_inc;
                            end
                        end
                        else
                        begin
                            rd_pos_next = '0;
                            wr_pos_next = '0;
                        end
                    end
                end
                default:
                begin
                    res_status = ST_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg  <= '0;
            rd_pos_reg  <= '0;
            open_reg    <= 1'b0;
            discard_reg <= 1'b0;
            remain_reg  <= 8'd0;
            sum_reg     <= 8'd0;
            seq_cnt_reg <= 3'd0;
        end
        else
        begin
            wr_pos_reg  <= wr_pos_next;
            rd_pos_reg  <= rd_pos_next;
            open_reg    <= open_next;
            discard_reg <= discard_next;
            remain_reg  <= remain_next;
            sum_reg     <= sum_next;
            seq_cnt_reg <= seq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_addr_reg <= seq_addr_next;
        seq_q_reg    <= seq_q_next;
    end

    ftb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_pos_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Pending stage (waits for RAM read data) and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (in_fire)
        begin
            p_valid_next = 1'b1;
        end
        else if (p_move)
        begin
            p_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (p_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p_read_reg   <= res_read;
            p_done_reg   <= res_done;
            p_status_reg <= res_status;
        end
        if (p_move)
        begin
            o_tx_valid_reg <= p_read_reg;
            o_tx_byte_reg  <= p_read_reg ? rd_data : 8'd0;
            o_done_reg     <= p_done_reg;
            o_status_reg   <= p_status_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign tx_valid        = o_tx_valid_reg;
    assign tx_byte         = o_tx_byte_reg;
    assign packet_complete = o_done_reg;
    assign status          = o_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rd_not_past_wr: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pos_reg <= wr_pos_reg)
        else $error("read position passed write position");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pos_reg <= PW'(BUFFER_DEPTH))
        else $error("write position beyond buffer");

    a_open_xor_discard: assert property (@(posedge clk) disable iff (!rst_n)
        !(open_reg && discard_reg))
        else $error("packet open while discarding");

    a_seq_only_when_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op == OP_READY) |-> (seq_cnt_reg == 3'd0 && !wr_en))
        else $error("buffer read while header or checksum write pending");

    a_tx_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tx_valid) |-> (status == ST_OK))
        else $error("byte sent with non ok status");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed packet transmit buffer: a short table of
// directed words, then random packet traffic shaped from the tracked buffer
// state, with random gaps and output stalls, over several sync byte settings.
// ----------------------------------------------------------------------------
module tb_top;
    import ftb_pkg::*;

    localparam int         DEPTH     = 128;
    localparam int         IDX_W     = $clog2(DEPTH);
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         PHASE_QUOTA = 375;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] data;
    } word_t;

    typedef struct packed {
        logic       txv;
        logic [7:0] txb;
        logic       done;
        status_t    st;
    } result_t;

    typedef struct {
        word_t   w;
        bit      typed;
        result_t r;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [7:0]  packet_id;
    logic [7:0]  payload_length;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        packet_complete;
    status_t     status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // tracked copy of the framer state
    logic [7:0]  frame_buf [DEPTH];
    int unsigned wr_pos;
    int unsigned rd_pos;
    bit          pkt_open;
    bit          dropping;
    int unsigned left;
    logic [7:0]  csum_acc;
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;

    result_t     expected_tx [$];
    row_t        script [$];
    int          errors = 0;
    int          hold_left = 0;
    bit          calm;

    framed_packet_tx_buffer #(
        .BUFFER_DEPTH(DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .packet_id      (packet_id),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tx_valid       (tx_valid),
        .tx_byte        (tx_byte),
        .packet_complete(packet_complete),
        .status         (status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("framed_packet_tx_buffer verification failed");
        $finish;
    end

    task automatic note_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic buf_put(input logic [7:0] b);
        if (wr_pos < DEPTH)
        begin
            frame_buf[IDX_W'(wr_pos)] = b;
            wr_pos++;
        end
    endtask

    // checksum is the negated 8-bit sum of id, length and payload
    task automatic seal_packet();
        buf_put(8'd0 - csum_acc);
        pkt_open = 0;
        left     = 0;
    endtask

    task automatic frame_step(input word_t w, output result_t r);
        r.txv  = 1'b0;
        r.txb  = 8'h00;
        r.done = 1'b0;
        r.st   = ST_IGNORED;
        case (w.op)
            OP_START:
                if (!pkt_open && !dropping)
                begin
                    if (FRAME_OVERHEAD + 32'(w.len) + wr_pos > DEPTH)
                    begin
                        r.st = ST_REJECTED;
                        if (w.len != 0)
                        begin
                            dropping = 1;
                            left     = 32'(w.len);
                        end
                    end
                    else
                    begin
                        r.st = ST_OK;
                        buf_put(sync_a);
                        buf_put(sync_b);
                        buf_put(w.id);
                        buf_put(w.len);
                        csum_acc = w.id + w.len;
                        pkt_open = 1;
                        left     = 32'(w.len);
                        if (w.len == 0)
                        begin
                            seal_packet();
                            r.done = 1'b1;
                        end
                    end
                end
            OP_DATA:
                if (pkt_open)
                begin
                    r.st = ST_OK;
                    buf_put(w.data);
                    csum_acc = csum_acc + w.data;
                    if (left > 0)
                        left--;
                    if (left == 0)
                    begin
                        seal_packet();
                        r.done = 1'b1;
                    end
                end
                else if (dropping)
                begin
                    r.st = ST_DISCARDED;
                    if (left > 0)
                        left--;
                    if (left == 0)
                        dropping = 0;
                end
            OP_READY:
                if (!pkt_open)
                begin
                    if (rd_pos < wr_pos)
                    begin
                        r.txv = 1'b1;
                        r.txb = frame_buf[IDX_W'(rd_pos)];
                        rd_pos++;
                        r.st = ST_OK;
                    end
                    if (rd_pos >= wr_pos)
                    begin
                        rd_pos = 0;
                        wr_pos = 0;
                    end
                end
            default: ;
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input word_t w, input bit typed, input result_t fixed,
                             output result_t r);
        int gap;
        gap = calm ? 0 : int'($urandom_range(0, 19));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        op             <= w.op;
        packet_id      <= w.id;
        payload_length <= w.len;
        data_byte      <= w.data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frame_step(w, r);
        if (typed)
            r = fixed;
        expected_tx.push_back(r);
        @(negedge clk);
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (expected_tx.size() != 0)
            @(negedge clk);
    endtask

    // write one sync register, then read it back
    task automatic set_sync(input logic idx, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_SYNC_FIRST)
            sync_a = v;
        else
            sync_b = v;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[7:0] !== v)
            note_mismatch($sformatf("reg %0d read %h, wrote %h", idx, prdata[7:0], v));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic script_row(input logic [1:0] o, input logic [7:0] id,
                              input logic [7:0] len, input logic [7:0] d,
                              input bit typed, input logic txv, input logic [7:0] txb,
                              input logic done, input status_t st);
        row_t row;
        row.w       = '{o, id, len, d};
        row.typed   = typed;
        row.r.txv   = txv;
        row.r.txb   = txb;
        row.r.done  = done;
        row.r.st    = st;
        script.push_back(row);
    endtask

    // random word shaped from the tracked state: mostly well-formed packets
    task automatic pick_word(output word_t w);
        int          roll;
        int          k;
        int unsigned room;
        w.op   = OP_READY;
        w.id   = 8'($urandom);
        w.len  = 8'($urandom);
        w.data = 8'($urandom);
        roll   = int'($urandom_range(0, 99));
        if (pkt_open || dropping)
        begin
            if (roll < 88)
                w.op = OP_DATA;
            else
                case ($urandom_range(0, 2))
                    0:       w.op = OP_START;
                    1:       w.op = OP_READY;
                    default: w.op = OP_UNUSED;
                endcase
        end
        else if (roll < 8)
            w.op = roll[0] ? OP_DATA : OP_UNUSED;
        else if (roll < ((wr_pos >= 100) ? 28 : 50))
        begin
            w.op = OP_START;
            room = (wr_pos <= DEPTH - FRAME_OVERHEAD) ? DEPTH - FRAME_OVERHEAD - wr_pos : 0;
            k    = int'($urandom_range(0, 39));
            if (wr_pos > DEPTH - FRAME_OVERHEAD && k < 12)
                w.len = 8'h00;                      // full buffer, empty packet
            else if (k < 30)
                w.len = 8'($urandom_range(0, 12));
            else if (k < 32)
                w.len = 8'h00;
            else if (k < 35)
                w.len = 8'(room);                   // fills the buffer exactly
            else if (k < 37)
                w.len = 8'(room + 1);               // one byte too long
            else if (k == 37)
                w.len = 8'($urandom_range(0, 255));
            else if (k == 38)
                w.len = 8'hFF;
            else
                w.len = 8'($urandom_range(13, 60));
        end
    endtask

    // result check at the rising edge, receiver stall driven at the falling edge
    always @(clk)
    begin
        result_t e;
        if (clk)
        begin
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_tx.size() == 0)
                    note_mismatch("result word with nothing expected");
                else
                begin
                    e = expected_tx.pop_front();
                    if (tx_valid !== e.txv || tx_byte !== e.txb ||
                        packet_complete !== e.done || status !== e.st)
                        note_mismatch($sformatf("got v%b b%h c%b s%0d, want v%b b%h c%b s%0d",
                            tx_valid, tx_byte, packet_complete, status,
                            e.txv, e.txb, e.done, e.st));
                end
                hold_left = calm ? 0 : int'($urandom_range(0, 19));
            end
        end
        else
        begin
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        word_t      w;
        result_t    r;
        result_t    none;
        int         n;
        logic [7:0] fa;
        logic [7:0] fb;

        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = OP_READY;
        packet_id      = 8'h00;
        payload_length = 8'h00;
        data_byte      = 8'h00;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 3'd0;
        pwdata         = 32'h0;
        calm           = 0;
        none           = '0;
        wr_pos         = 0;
        rd_pos         = 0;
        pkt_open       = 0;
        dropping       = 0;
        left           = 0;
        csum_acc       = 8'h00;
        sync_a         = 8'h00;
        sync_b         = 8'h00;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words, sync bytes still at their reset value
        script_row(OP_READY,  8'h00, 8'h00, 8'h00, 1, 0, 8'h00, 0, ST_IGNORED);
        script_row(OP_DATA,   8'h00, 8'h00, 8'hA5, 1, 0, 8'h00, 0, ST_IGNORED);
        script_row(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1, 0, 8'h00, 0, ST_IGNORED);
        script_row(OP_START,  8'hFF, 8'h00, 8'h00, 1, 0, 8'h00, 1, ST_OK);
        script_row(OP_READY,  8'h00, 8'h00, 8'h00, 1, 1, 8'h00, 0, ST_OK);
        script_row(OP_START,  8'h12, 8'h03, 8'h00, 0, 0, 8'h00, 0, ST_OK);
        script_row(OP_START,  8'h34, 8'h01, 8'h00, 1, 0, 8'h00, 0, ST_IGNORED);
        script_row(OP_READY,  8'h00, 8'h00, 8'h00, 1, 0, 8'h00, 0, ST_IGNORED);
        script_row(OP_DATA,   8'h00, 8'h00, 8'h00, 0, 0, 8'h00, 0, ST_OK);
        script_row(OP_DATA,   8'h00, 8'h00, 8'hFF, 0, 0, 8'h00, 0, ST_OK);
        script_row(OP_DATA,   8'h00, 8'h00, 8'h80, 0, 0, 8'h00, 0, ST_OK);
        script_row(OP_READY,  8'h00, 8'h00, 8'h00, 0, 0, 8'h00, 0, ST_OK);
        script_row(OP_READY,  8'h00, 8'h00, 8'h00, 0, 0, 8'h00, 0, ST_OK);
        script_row(OP_READY,  8'h00, 8'h00, 8'h00, 0, 0, 8'h00, 0, ST_OK);
        script_row(OP_START,  8'h00, 8'hFF, 8'h00, 1, 0, 8'h00, 0, ST_REJECTED);
        script_row(OP_START,  8'h55, 8'h02, 8'h00, 1, 0, 8'h00, 0, ST_IGNORED);
        script_row(OP_READY,  8'h00, 8'h00, 8'h00, 0, 0, 8'h00, 0, ST_OK);
        script_row(OP_DATA,   8'h00, 8'h00, 8'h7E, 1, 0, 8'h00, 0, ST_DISCARDED);
        script_row(OP_DATA,   8'h00, 8'h00, 8'hFF, 1, 0, 8'h00, 0, ST_DISCARDED);
        foreach (script[i])
            send_word(script[i].w, script[i].typed, script[i].r, r);

        for (int p = 0; p < 4; p++)
        begin
            // sync bytes only change with nothing in flight
            go_quiet();
            wait_drained();
            repeat (6) @(negedge clk);
            case (p)
                0:       begin fa = 8'hFF; fb = 8'h00; end
                1:       begin fa = 8'h00; fb = 8'hFF; end
                2:       begin fa = 8'hA5; fb = 8'h5A; end
                default: begin fa = 8'($urandom); fb = 8'($urandom); end
            endcase
            set_sync(REG_SYNC_FIRST, fa);
            set_sync(REG_SYNC_SECOND, fb);

            n = 0;
            while (n < PHASE_QUOTA)
            begin
                if (n % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                n++;
                pick_word(w);
                send_word(w, 0, none, r);
                if ($urandom_range(0, 249) == 0)
                begin
                    go_quiet();
                    wait_drained();
                end
            end
        end

        go_quiet();
        wait_drained();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("framed_packet_tx_buffer verification clean");
        else
            $display("framed_packet_tx_buffer verification failed");
        $finish;
    end

endmodule

[filelist.f]
src/ftb_pkg.sv
src/ftb_ram.sv
src/framed_packet_tx_buffer.sv
test/tb_top.sv
